// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fust_pkg.sv
// Package with the shared types, constants and reset values of the session tracker.
`default_nettype none

package fust_pkg;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int FLEN_W     = 11;
    localparam int REPLY_W    = 3;
    localparam int WOFF_W     = 24;
    localparam int TICK_W     = 16;
    localparam int SECT_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Structural defaults.
    localparam int SECTOR_BYTES_DEF = 1024 * 8;
    localparam int OFFSET_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Frame header and commands.
    localparam logic [BYTE_W-1:0] HDR0       = 8'h7E;
    localparam logic [BYTE_W-1:0] HDR1       = 8'h00;
    localparam logic [BYTE_W-1:0] HDR2       = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_START  = 8'hF3;
    localparam logic [BYTE_W-1:0] CMD_DATA   = 8'hF5;
    localparam logic [BYTE_W-1:0] CMD_FINISH = 8'hF7;

    // Payload bytes are the frame minus this many framing bytes.
    localparam logic [FLEN_W-1:0] FRAME_OVERHEAD = 11'd9;
    localparam logic [FLEN_W-1:0] MIN_DATA_LEN   = 11'd8;

    // Reply codes.
    localparam logic [REPLY_W-1:0] RC_NONE   = 3'd0;
    localparam logic [REPLY_W-1:0] RC_START  = 3'd1;
    localparam logic [REPLY_W-1:0] RC_DATA   = 3'd2;
    localparam logic [REPLY_W-1:0] RC_FINISH = 3'd3;
    localparam logic [REPLY_W-1:0] RC_ERROR  = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES       = 2'd3;

    // Register reset values.
    localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST    = 16'd5000;
    localparam logic [BYTE_W-1:0] START_THRESHOLD_RST  = 8'd3;
    localparam logic [BYTE_W-1:0] FINISH_THRESHOLD_RST = 8'd3;
    localparam logic [BYTE_W-1:0] MIN_FRAMES_RST       = 8'd10;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_START,
        KIND_DATA,
        KIND_FINISH,
        KIND_OTHER
    } kind_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W:0]   seq_plus1;
        logic              long_frame;
        logic [FLEN_W-1:0] payload_len;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_limit;
        logic [BYTE_W-1:0] start_threshold;
        logic [BYTE_W-1:0] finish_threshold;
        logic [BYTE_W-1:0] min_frames;
    } cfg_t;

    typedef struct packed {
        logic [REPLY_W-1:0] reply_code;
        logic               erase_request;
        logic               write_request;
        logic [WOFF_W-1:0]  write_offset;
        logic [FLEN_W-1:0]  write_length;
        logic               update_done;
        logic               timed_out;
        logic               session_open;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/fust_front.sv
// Front end: input handshake and classification of frames and ticks.
`default_nettype none

module fust_front
    import fust_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [BYTE_W-1:0] first_byte,
    input  wire logic [BYTE_W-1:0] second_byte,
    input  wire logic [BYTE_W-1:0] third_byte,
    input  wire logic [BYTE_W-1:0] command,
    input  wire logic [BYTE_W-1:0] sequence_req,
    input  wire logic [FLEN_W-1:0] frame_length,
    input  wire logic              q_full,
    output logic                   push,
    output item_t                  item
);

    logic hdr_ok;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign hdr_ok   = (first_byte == HDR0) && (second_byte == HDR1) && (third_byte == HDR2);

    always_comb
    begin
        item.seq         = sequence_req;
        item.seq_plus1   = {1'b0, sequence_req} + 9'd1;
        item.long_frame  = frame_length > MIN_DATA_LEN;
        item.payload_len = frame_length - FRAME_OVERHEAD;
        if (op)
        begin
            item.kind = KIND_TICK;
        end
        else if (!hdr_ok)
        begin
            item.kind = KIND_OTHER;
        end
        else
        begin
            unique case (command)
                CMD_START:  item.kind = KIND_START;
                CMD_DATA:   item.kind = KIND_DATA;
                CMD_FINISH: item.kind = KIND_FINISH;
                default:    item.kind = KIND_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fust_queue.sv
// Short queue of classified words between the front and the back.
`default_nettype none

module fust_queue
    import fust_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       q_valid,
    output item_t      head
);

    item_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fust_back.sv
// Back end: session state, sector erase bookkeeping and the output register.
`default_nettype none

module fust_back
    import fust_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output result_t    result
);

    localparam int SB_W    = $clog2(SECTOR_BYTES + 1);
    localparam int LIMIT_W = SECT_W + SB_W;
    localparam int CMP_W   = (OFFSET_BITS > LIMIT_W) ? OFFSET_BITS : LIMIT_W;
    localparam int WEXT_W  = (OFFSET_BITS > WOFF_W) ? OFFSET_BITS : WOFF_W;
    localparam logic [LIMIT_W-1:0] SECTOR_STEP = LIMIT_W'(SECTOR_BYTES);

    logic                   active_reg,      active_next;
    logic [BYTE_W-1:0]      frame_cnt_reg,   frame_cnt_next;
    logic [BYTE_W-1:0]      start_cnt_reg,   start_cnt_next;
    logic [BYTE_W-1:0]      finish_cnt_reg,  finish_cnt_next;
    logic [SECT_W-1:0]      sectors_reg,     sectors_next;
    // Running product of erased sectors and the sector size.
    logic [LIMIT_W-1:0]     erased_end_reg,  erased_end_next;
    logic [OFFSET_BITS-1:0] offset_reg,      offset_next;
    logic [TICK_W-1:0]      idle_reg,        idle_next;
    logic                   out_valid_reg,   out_valid_next;
    result_t                result_reg,      result_next;

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        logic             drop;
        logic [WEXT_W-1:0] off_ext;

        drop            = 1'b0;
        off_ext         = WEXT_W'(offset_reg);
        active_next     = active_reg;
        frame_cnt_next  = frame_cnt_reg;
        start_cnt_next  = start_cnt_reg;
        finish_cnt_next = finish_cnt_reg;
        sectors_next    = sectors_reg;
        erased_end_next = erased_end_reg;
        offset_next     = offset_reg;
        idle_next       = idle_reg;
        result_next     = '0;

        if (head.kind == KIND_TICK)
        begin
            if (idle_reg != '1)
            begin
                idle_next = idle_reg + 1'b1;
            end
            if (idle_next > cfg.timeout_limit)
            begin
                idle_next = '0;
                if (active_reg)
                begin
                    drop                  = 1'b1;
                    result_next.timed_out = 1'b1;
                end
            end
        end
        else
        begin
            if (active_reg && (finish_cnt_reg == '0))
            begin
                frame_cnt_next = frame_cnt_reg + 1'b1;
            end
            unique case (head.kind)
                KIND_START:
                begin
                    start_cnt_next = start_cnt_reg + 1'b1;
                    if ((start_cnt_next > cfg.start_threshold) && !active_reg)
                    begin
                        result_next.reply_code = RC_START;
                        idle_next              = '0;
                        drop                   = 1'b1;
                    end
                end
                KIND_DATA:
                begin
                    if (active_reg)
                    begin
                        if (head.seq == frame_cnt_next)
                        begin
                            if (head.long_frame)
                            begin
                                if (CMP_W'(offset_reg) >= CMP_W'(erased_end_reg))
                                begin
                                    result_next.erase_request = 1'b1;
                                    sectors_next    = sectors_reg + 1'b1;
                                    erased_end_next = (sectors_reg == '1) ? '0
                                                    : erased_end_reg + SECTOR_STEP;
                                end
                                result_next.write_request = 1'b1;
                                result_next.write_offset  = off_ext[WOFF_W-1:0];
                                result_next.write_length  = head.payload_len;
                                result_next.reply_code    = RC_DATA;
                                offset_next = offset_reg + OFFSET_BITS'(head.payload_len);
                            end
                            idle_next = '0;
                        end
                        else
                        begin
                            result_next.reply_code = RC_ERROR;
                            drop                   = 1'b1;
                        end
                    end
                end
                KIND_FINISH:
                begin
                    finish_cnt_next = finish_cnt_reg + 1'b1;
                    if (active_reg)
                    begin
                        if (({1'b0, frame_cnt_next} == head.seq_plus1)
                            && (frame_cnt_next > cfg.min_frames))
                        begin
                            if (finish_cnt_next > cfg.finish_threshold)
                            begin
                                result_next.reply_code  = RC_FINISH;
                                result_next.update_done = 1'b1;
                                drop                    = 1'b1;
                                idle_next               = '0;
                            end
                        end
                        else
                        begin
                            result_next.reply_code = RC_ERROR;
                            drop                   = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (drop)
        begin
            active_next     = 1'b0;
            frame_cnt_next  = '0;
            start_cnt_next  = '0;
            finish_cnt_next = '0;
            sectors_next    = '0;
            erased_end_next = '0;
            offset_next     = '0;
        end
        // A start acknowledge opens the session after the clear.
        if (result_next.reply_code == RC_START)
        begin
            active_next = 1'b1;
        end
        result_next.session_open = active_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            frame_cnt_reg  <= '0;
            start_cnt_reg  <= '0;
            finish_cnt_reg <= '0;
            sectors_reg    <= '0;
            erased_end_reg <= '0;
            offset_reg     <= '0;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                active_reg     <= active_next;
                frame_cnt_reg  <= frame_cnt_next;
                start_cnt_reg  <= start_cnt_next;
                finish_cnt_reg <= finish_cnt_next;
                sectors_reg    <= sectors_next;
                erased_end_reg <= erased_end_next;
                offset_reg     <= offset_next;
                idle_reg       <= idle_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/firmware_update_session_tracker_top.sv
// An accepted word is written into a queue slot, then into the output register that drives out_valid.
// Throughput: one word per cycle, sustained as long as the output side does not stall.
// A two-entry queue sits between the classifier and the state update; in steady streaming
// one entry is in use, so a stalled output lets one more word in before in_stall rises.
// Reset (rst_n low, asynchronous) closes the session, clears all counters and the queue,
// and loads the register defaults; there is no clearing pass after reset.
`default_nettype none

module firmware_update_session_tracker_top
    import fust_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [BYTE_W-1:0]     first_byte,
    input  wire logic [BYTE_W-1:0]     second_byte,
    input  wire logic [BYTE_W-1:0]     third_byte,
    input  wire logic [BYTE_W-1:0]     command,
    input  wire logic [BYTE_W-1:0]     sequence_req,
    input  wire logic [FLEN_W-1:0]     frame_length,
    // Output channel.
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [REPLY_W-1:0]         reply_code,
    output logic                       erase_request,
    output logic                       write_request,
    output logic [WOFF_W-1:0]          write_offset,
    output logic [FLEN_W-1:0]          write_length,
    output logic                       update_done,
    output logic                       timed_out,
    output logic                       session_open
);

`include "assert_macros.svh"

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    q_full;
    logic    push;
    item_t   push_item;
    logic    pop;
    logic    q_valid;
    item_t   head;
    result_t result;

    // Configuration registers. Writes must arrive only while the tracker is idle; the block does
    // not enforce this, and the back end reads them directly without any shadowing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_LIMIT:    cfg_next.timeout_limit    = cfg_data;
                CFG_START_THRESHOLD:  cfg_next.start_threshold  = cfg_data[BYTE_W-1:0];
                CFG_FINISH_THRESHOLD: cfg_next.finish_threshold = cfg_data[BYTE_W-1:0];
                CFG_MIN_FRAMES:       cfg_next.min_frames       = cfg_data[BYTE_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit    <= TIMEOUT_LIMIT_RST;
            cfg_reg.start_threshold  <= START_THRESHOLD_RST;
            cfg_reg.finish_threshold <= FINISH_THRESHOLD_RST;
            cfg_reg.min_frames       <= MIN_FRAMES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end checks the header and sorts each word into a tick, a start,
    // a data frame, a finish or an ignored frame, and precomputes the payload length.
    fust_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .third_byte   (third_byte),
        .command      (command),
        .sequence_req (sequence_req),
        .frame_length (frame_length),
        .q_full       (q_full),
        .push         (push),
        .item         (push_item)
    );

    fust_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    // The back end owns the session state and the output register. It takes the
    // queue head whenever the output register is empty or is being read.
    fust_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign reply_code    = result.reply_code;
    assign erase_request = result.erase_request;
    assign write_request = result.write_request;
    assign write_offset  = result.write_offset;
    assign write_length  = result.write_length;
    assign update_done   = result.update_done;
    assign timed_out     = result.timed_out;
    assign session_open  = result.session_open;

    // A completed update always carries the finish acknowledge and leaves the session closed.
    `ASSERT_IMPLIES(a_done_closes, out_valid && update_done,
        (reply_code == RC_FINISH) && !session_open, "update_done without a clean finish")

    // An erase request only ever comes with the write that needs it.
    `ASSERT_IMPLIES(a_erase_with_write, out_valid && erase_request,
        write_request && (reply_code == RC_DATA), "erase request without a data write")

    // When a result is taken and the queue is empty, no new result may appear.
    `ASSERT_NEXT(a_no_invented_result, out_valid && !out_stall && !q_valid,
        !out_valid, "result appeared without a queued word")

endmodule

`default_nettype wire
